// ===== rtl/core/hbaf_pkg.sv =====
// Shared types and constants of the implicit-list heap block allocator.
// Used by the header memory and by the allocator top level.
// Depends on nothing.
package hbaf_pkg;

  // Heap geometry.
  localparam int unsigned HEAP_BYTES = 4096;
  localparam int unsigned HDR_BYTES  = 8;

  // Fixed widths of the stream fields.
  localparam int unsigned MODE_W = 2;
  localparam int unsigned REQ_W  = 12;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned SIZE_W = 13;

  // Header memory index, heap end register and wide offset arithmetic.
  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned EW = AW + 1;
  localparam int unsigned SW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned IN_BITS  = MODE_W + REQ_W + ADDR_W;
  localparam int unsigned OUT_BITS = ADDR_W + 1;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_FREE  = 2'd2
  } mode_e;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOH = 1'b1;

  // One block header: free flag over the total block size.
  typedef struct packed {
    logic              fr;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // Write request into the header memory.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    hdr_t          data;
  } hdr_wr_t;

endpackage

// ===== rtl/core/hbaf_hdr_ram.sv =====
// Header memory of the allocator: one block header per heap byte offset.
// Single write port, single read port with registered read data.
// Depends on hbaf_pkg.
module hbaf_hdr_ram (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [hbaf_pkg::AW-1:0] rd_addr_i,
  input  hbaf_pkg::hdr_wr_t    wr_i,
  output hbaf_pkg::hdr_t       rd_data_o
);

  hbaf_pkg::hdr_t hdr_mem [hbaf_pkg::HEAP_BYTES];
  hbaf_pkg::hdr_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      hdr_mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= hdr_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/heap_block_allocator_fit.sv =====
// Implicit-list heap allocator with first-fit, best-fit and free operations.
// Depends on hbaf_pkg and hbaf_hdr_ram.
//
// Usage: each request word on the slave stream (s_axis) carries a mode, a
// request size and a free address; exactly one result word follows on the
// master stream (m_axis) with the user address and a status bit.
// Block headers live in a single-port-write memory with registered read
// data; the allocator walks the list one header per cycle, feeding the
// next read address from the size just read.
// Steps from accept to the result hand-off:
//   allocate: header walk (all blocks for best fit, up to the first fit
//             for first fit, none on an empty heap), resolve, and split
//             when the taken block is split;
//   free:     header read, then write-back; bad address or unused mode: none.
// One request is worked on at a time; the next request is taken once the
// result has moved into the output register, so a result that waits for the
// receiver does not hold off the next request.
// When the receiver stalls with a full output register, a finished result
// waits inside and no new request is taken.
// Reset empties the heap (heap end back to 0) and drops any pending result;
// the header memory is not cleared since the list never reaches unwritten
// entries.
module heap_block_allocator_fit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: mode[1:0], req_bytes[13:2], free_addr[25:14].
  input  logic [hbaf_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // Fields from bit 0: user_addr[11:0], status[12].
  output logic [hbaf_pkg::OUT_W-1:0]  m_axis_tdata
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_WALK    = 7'b0000010,
    ST_RESOLVE = 7'b0000100,
    ST_SPLIT   = 7'b0001000,
    ST_FREE_WR = 7'b0010000,
    ST_DONE    = 7'b0100000
  } state_e;

  localparam int unsigned AW = hbaf_pkg::AW;
  localparam int unsigned EW = hbaf_pkg::EW;
  localparam int unsigned SW = hbaf_pkg::SW;
  localparam int unsigned SIZE_W = hbaf_pkg::SIZE_W;
  localparam int unsigned ADDR_W = hbaf_pkg::ADDR_W;

  state_e                state_q, state_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         pick_q, pick_d;
  logic [SIZE_W-1:0]     pick_sz_q, pick_sz_d;
  logic                  found_q, found_d;
  logic                  best_q, best_d;
  logic [SIZE_W-1:0]     need_q, need_d;
  logic [EW-1:0]         heap_end_q, heap_end_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic                  res_status_q, res_status_d;
  logic                  out_vld_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic                  out_status_q;
  logic                  out_load;

  // Header memory access.
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  hbaf_pkg::hdr_wr_t     hdr_wr;
  hbaf_pkg::hdr_t        rd_hdr;

  // Input field extraction.
  logic [hbaf_pkg::MODE_W-1:0] in_mode;
  logic [hbaf_pkg::REQ_W-1:0]  in_req;
  logic [ADDR_W-1:0]           in_addr;

  // Offset arithmetic.
  logic [SW-1:0]         free_hdr;
  logic                  free_ok;
  logic [SW-1:0]         walk_nxt;
  logic                  walk_fit;
  logic [SW-1:0]         take_rest;
  logic [SW-1:0]         take_next;
  logic                  take_split;
  logic [SW-1:0]         grow_sum;
  logic                  grow_over;

  assign in_mode = s_axis_tdata[hbaf_pkg::MODE_W-1:0];
  assign in_req  = s_axis_tdata[hbaf_pkg::MODE_W +: hbaf_pkg::REQ_W];
  assign in_addr = s_axis_tdata[hbaf_pkg::MODE_W + hbaf_pkg::REQ_W +: ADDR_W];

  hbaf_hdr_ram u_hdr_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (hdr_wr),
    .rd_data_o (rd_hdr)
  );

  // Header offset of a free and its range check.
  assign free_hdr = SW'(in_addr) - SW'(hbaf_pkg::HDR_BYTES);
  assign free_ok  = (in_addr >= ADDR_W'(hbaf_pkg::HDR_BYTES)) &&
                    (free_hdr < SW'(hbaf_pkg::HEAP_BYTES));

  // Next block during the walk and the fit test on the current header.
  assign walk_nxt = SW'(cur_q) + SW'(rd_hdr.size);
  assign walk_fit = rd_hdr.fr && (rd_hdr.size >= need_q);

  // Split decision for the chosen block.
  assign take_rest  = SW'(pick_q) + SW'(need_q);
  assign take_next  = SW'(pick_q) + SW'(pick_sz_q);
  assign take_split = (take_rest + SW'(hbaf_pkg::HDR_BYTES)) < take_next;

  // Growth at the heap end.
  assign grow_sum  = SW'(heap_end_q) + SW'(need_q);
  assign grow_over = grow_sum > SW'(hbaf_pkg::HEAP_BYTES);

  assign s_axis_tready = (state_q == ST_IDLE);

  // Sequencer: list walk, take or grow, free, then result hand-off.
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    pick_d       = pick_q;
    pick_sz_d    = pick_sz_q;
    found_d      = found_q;
    best_d       = best_q;
    need_d       = need_q;
    heap_end_d   = heap_end_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = cur_q;
    hdr_wr       = '0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_mode) inside
            hbaf_pkg::MODE_FIRST, hbaf_pkg::MODE_BEST: begin
              need_d  = SIZE_W'(in_req) + SIZE_W'(hbaf_pkg::HDR_BYTES);
              best_d  = (in_mode == hbaf_pkg::MODE_BEST);
              found_d = 1'b0;
              cur_d   = '0;
              if (heap_end_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = ST_WALK;
              end else begin
                state_d = ST_RESOLVE;
              end
            end
            hbaf_pkg::MODE_FREE: begin
              res_addr_d   = in_addr;
              res_status_d = hbaf_pkg::STATUS_OK;
              if (free_ok) begin
                cur_d   = free_hdr[AW-1:0];
                rd_en   = 1'b1;
                rd_addr = free_hdr[AW-1:0];
                state_d = ST_FREE_WR;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              res_addr_d   = '0;
              res_status_d = hbaf_pkg::STATUS_OK;
              state_d      = ST_DONE;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (rd_hdr.size == '0) begin
          // A zero-size header ends the list.
          state_d = ST_RESOLVE;
        end else begin
          if (walk_fit && (!found_q || (best_q && (pick_sz_q > rd_hdr.size)))) begin
            pick_d    = cur_q;
            pick_sz_d = rd_hdr.size;
            found_d   = 1'b1;
          end
          if (walk_fit && !best_q) begin
            state_d = ST_RESOLVE;
          end else if ((walk_nxt < SW'(heap_end_q)) &&
                       (walk_nxt < SW'(hbaf_pkg::HEAP_BYTES))) begin
            cur_d   = walk_nxt[AW-1:0];
            rd_en   = 1'b1;
            rd_addr = walk_nxt[AW-1:0];
          end else begin
            state_d = ST_RESOLVE;
          end
        end
      end

      ST_RESOLVE: begin
        if (found_q) begin
          hdr_wr.we      = 1'b1;
          hdr_wr.addr    = pick_q;
          hdr_wr.data.fr = 1'b0;
          res_addr_d     = ADDR_W'(SW'(pick_q) + SW'(hbaf_pkg::HDR_BYTES));
          res_status_d   = hbaf_pkg::STATUS_OK;
          if (take_split) begin
            hdr_wr.data.size = need_q;
            state_d          = ST_SPLIT;
          end else begin
            hdr_wr.data.size = pick_sz_q;
            state_d          = ST_DONE;
          end
        end else if (grow_over) begin
          res_addr_d   = '0;
          res_status_d = hbaf_pkg::STATUS_OOH;
          state_d      = ST_DONE;
        end else begin
          hdr_wr.we        = 1'b1;
          hdr_wr.addr      = heap_end_q[AW-1:0];
          hdr_wr.data.fr   = 1'b0;
          hdr_wr.data.size = need_q;
          res_addr_d       = ADDR_W'(SW'(heap_end_q) + SW'(hbaf_pkg::HDR_BYTES));
          res_status_d     = hbaf_pkg::STATUS_OK;
          heap_end_d       = grow_sum[EW-1:0];
          state_d          = ST_DONE;
        end
      end

      ST_SPLIT: begin
        // The remainder of a split block becomes a free block.
        hdr_wr.we        = 1'b1;
        hdr_wr.addr      = take_rest[AW-1:0];
        hdr_wr.data.fr   = 1'b1;
        hdr_wr.data.size = SIZE_W'(take_next - take_rest);
        state_d          = ST_DONE;
      end

      ST_FREE_WR: begin
        hdr_wr.we        = 1'b1;
        hdr_wr.addr      = cur_q;
        hdr_wr.data.fr   = 1'b1;
        hdr_wr.data.size = rd_hdr.size;
        state_d          = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      found_q    <= 1'b0;
      best_q     <= 1'b0;
      heap_end_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      found_q    <= found_d;
      best_q     <= best_d;
      heap_end_q <= heap_end_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    pick_q       <= pick_d;
    pick_sz_q    <= pick_sz_d;
    need_q       <= need_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(hbaf_pkg::OUT_W - hbaf_pkg::OUT_BITS){1'b0}},
                          out_status_q, out_addr_q};

  // The heap end never passes the heap size.
  a_heap_end_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_end_q <= EW'(hbaf_pkg::HEAP_BYTES))
    else $error("heap end beyond heap size");

  // Header writes come only from take, split, growth and free steps.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_wr.we |-> (state_q == ST_RESOLVE || state_q == ST_SPLIT ||
                   state_q == ST_FREE_WR))
    else $error("header write outside an update step");

  // An accepted request always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("accepted request left the sequencer idle");

  // A chosen block lies inside the heap.
  a_pick_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESOLVE && found_q) |-> (EW'(pick_q) < heap_end_q))
    else $error("chosen block beyond heap end");

  // A result is handed to the output only when the register is free.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready))
    else $error("output register overwritten");

endmodule
